// ===== src/udsn_pkg.sv =====
// udsn_pkg: widths, transfer payload types and lead-byte codes for the
// UTF-8 decoder with script normalisation. No dependencies.
package udsn_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 21;
    localparam int LEFT_W = 2;

    // Continuation bytes still awaited after each lead byte class
    localparam logic [LEFT_W-1:0] LEFT_NONE  = 2'd0;
    localparam logic [LEFT_W-1:0] LEFT_TWO   = 2'd1;
    localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd2;
    localparam logic [LEFT_W-1:0] LEFT_FOUR  = 2'd3;

    localparam logic [CODE_W-1:0] SPACE_CODE = 21'h000020;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic              has_code;
        logic              bad_lead;
        logic              text_done;
    } t_code_item;

endpackage

// ===== src/udsn_if.sv =====
// udsn_if: valid/ready channel interfaces for the byte input and the
// code point results. Depends on udsn_pkg.
interface udsn_byte_if;
    logic                        valid;
    logic                        ready;
    logic [udsn_pkg::BYTE_W-1:0] text_byte;
    logic                        end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface udsn_code_if;
    logic                        valid;
    logic                        ready;
    logic [udsn_pkg::CODE_W-1:0] code_point;
    logic                        has_code;
    logic                        bad_lead;
    logic                        text_done;

    modport source (output valid, output code_point, output has_code,
                    output bad_lead, output text_done, input ready);
    modport sink   (input valid, input code_point, input has_code,
                    input bad_lead, input text_done, output ready);
endinterface

// ===== src/udsn_decode.sv =====
// udsn_decode: UTF-8 sequence assembly with its decode state and the first
// pipeline register. Depends on udsn_pkg and udsn_if.
module udsn_decode (
    input  logic         i_clk,
    input  logic         i_rst_n,
    udsn_byte_if.sink    i_byte,
    udsn_code_if.source  o_raw
);

    logic [udsn_pkg::CODE_W-1:0] r_partial, n_partial;
    logic [udsn_pkg::LEFT_W-1:0] r_left, n_left;
    logic                        r_aborted, n_aborted;
    logic                        r_valid, n_valid;
    udsn_pkg::t_code_item        r_item, n_item;

    logic                        accept;
    logic                        emit;
    logic [udsn_pkg::BYTE_W-1:0] b;
    logic                        eot;
    logic [udsn_pkg::CODE_W-1:0] cont_code;

    assign i_byte.ready = !r_valid || o_raw.ready;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.text_byte;
    assign eot          = i_byte.end_of_text;
    assign cont_code    = {r_partial[udsn_pkg::CODE_W-7:0], b[5:0]};

    always_comb begin
        n_partial = r_partial;
        n_left    = r_left;
        n_aborted = r_aborted;
        n_item    = r_item;
        emit      = 1'b0;
        if (accept) begin
            if (r_aborted) begin
                // drop everything up to end of text
                if (eot) begin
                    n_aborted = 1'b0;
                    emit      = 1'b1;
                    n_item    = '{code_point: '0, has_code: 1'b0, bad_lead: 1'b1,
                                  text_done: 1'b1};
                end
            end else if (r_left == udsn_pkg::LEFT_NONE) begin
                if (b inside {[8'h00:8'h7F]}) begin
                    emit   = 1'b1;
                    n_item = '{code_point: {13'd0, b}, has_code: 1'b1, bad_lead: 1'b0,
                               text_done: eot};
                end else if (b inside {[8'hC0:8'hDF], [8'hE0:8'hEF], [8'hF0:8'hF3]}) begin
                    if (b inside {[8'hC0:8'hDF]}) begin
                        n_partial = {16'd0, b[4:0]};
                        n_left    = udsn_pkg::LEFT_TWO;
                    end else if (b inside {[8'hE0:8'hEF]}) begin
                        n_partial = {17'd0, b[3:0]};
                        n_left    = udsn_pkg::LEFT_THREE;
                    end else begin
                        n_partial = {18'd0, b[2:0]};
                        n_left    = udsn_pkg::LEFT_FOUR;
                    end
                    if (eot) begin
                        // truncated sequence: end-only result
                        n_partial = '0;
                        n_left    = udsn_pkg::LEFT_NONE;
                        emit      = 1'b1;
                        n_item    = '{code_point: '0, has_code: 1'b0, bad_lead: 1'b0,
                                      text_done: 1'b1};
                    end
                end else begin
                    n_partial = '0;
                    n_aborted = !eot;
                    emit      = 1'b1;
                    n_item    = '{code_point: '0, has_code: 1'b0, bad_lead: 1'b1,
                                  text_done: eot};
                end
            end else begin
                n_left = r_left - 2'd1;
                if (r_left == udsn_pkg::LEFT_TWO) begin
                    n_partial = '0;
                    emit      = 1'b1;
                    n_item    = '{code_point: cont_code, has_code: 1'b1, bad_lead: 1'b0,
                                  text_done: eot};
                end else if (eot) begin
                    n_partial = '0;
                    n_left    = udsn_pkg::LEFT_NONE;
                    emit      = 1'b1;
                    n_item    = '{code_point: '0, has_code: 1'b0, bad_lead: 1'b0,
                                  text_done: 1'b1};
                end else begin
                    n_partial = cont_code;
                end
            end
        end
        if (emit) begin
            n_valid = 1'b1;
        end else if (o_raw.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_left    <= udsn_pkg::LEFT_NONE;
            r_aborted <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_partial <= n_partial;
            r_left    <= n_left;
            r_aborted <= n_aborted;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_item <= n_item;
        end
    end

    assign o_raw.valid      = r_valid;
    assign o_raw.code_point = r_item.code_point;
    assign o_raw.has_code   = r_item.has_code;
    assign o_raw.bad_lead   = r_item.bad_lead;
    assign o_raw.text_done  = r_item.text_done;

endmodule

// ===== src/udsn_fold.sv =====
// udsn_fold: script folding of decoded code points and the result register.
// Depends on udsn_pkg and udsn_if.
module udsn_fold (
    input  logic         i_clk,
    input  logic         i_rst_n,
    udsn_code_if.sink    i_raw,
    udsn_code_if.source  o_code
);

    logic                        r_valid, n_valid;
    udsn_pkg::t_code_item        r_item;
    logic                        accept;
    logic [udsn_pkg::CODE_W-1:0] c;
    logic [udsn_pkg::CODE_W-1:0] folded;

    assign i_raw.ready = !r_valid || o_code.ready;
    assign accept      = i_raw.valid && i_raw.ready;
    assign c           = i_raw.code_point;

    always_comb begin
        folded = c;
        if (c <= 21'h00007F) begin
            if (c <= 21'h000040 || c inside {[21'h00005B:21'h000060]} || c >= 21'h00007B) begin
                folded = udsn_pkg::SPACE_CODE;
            end
        end else if (c <= 21'h0000FF) begin
            if (c inside {21'h0000A0, 21'h0000AB, 21'h0000B0, 21'h0000BB}) begin
                folded = udsn_pkg::SPACE_CODE;
            end
        end else if (c inside {[21'h000180:21'h00024F]}) begin
            if (c == 21'h000219) begin
                folded = 21'h00015F;
            end else if (c == 21'h00021B) begin
                folded = 21'h000163;
            end
        end else if (c inside {[21'h002000:21'h00206F]}) begin
            folded = udsn_pkg::SPACE_CODE;
        end else if (c == 21'h0006CC) begin
            folded = 21'h00064A;
        end else if (c == 21'h001EA0) begin
            folded = 21'h001EC3;
        end else if (c inside {[21'h003040:21'h00309F]}) begin
            folded = 21'h003042;
        end else if (c inside {[21'h0030A0:21'h0030FF]}) begin
            folded = 21'h0030A2;
        end else if (c inside {[21'h003100:21'h00312F], [21'h0031A0:21'h0031BF]}) begin
            folded = 21'h003105;
        end else if (c inside {[21'h00AC00:21'h00D7AF]}) begin
            folded = 21'h00AC00;
        end
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_code.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // hold the result while the sink stalls; fold only real characters
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.code_point <= i_raw.has_code ? folded : c;
            r_item.has_code   <= i_raw.has_code;
            r_item.bad_lead   <= i_raw.bad_lead;
            r_item.text_done  <= i_raw.text_done;
        end
    end

    assign o_code.valid      = r_valid;
    assign o_code.code_point = r_item.code_point;
    assign o_code.has_code   = r_item.has_code;
    assign o_code.bad_lead   = r_item.bad_lead;
    assign o_code.text_done  = r_item.text_done;

endmodule

// ===== src/utf8_decode_script_normalize.sv =====
// UTF-8 decoder with script normalisation. One byte is taken per transfer on
// i_byte, and the block accepts a byte in every cycle while the result side
// keeps up: throughput is one byte per clock. A byte that finishes a
// character, an invalid lead byte, or the end-of-text byte of a truncated or
// aborted text produces one result transfer on o_code, which the byte reaches
// through the decode register and then folding and the result register; other
// bytes produce nothing. Both stages are registered
// with a valid flag and take a new entry whenever they are empty or are
// emptying in the same cycle, so i_byte.ready follows o_code.ready through
// two gates per stage and a stalled result never blocks a byte until both
// registers are full. Code points of 1 to 4 byte sequences are folded by
// script: ASCII non-letters and some Latin-1 marks and general punctuation
// become space, a few Romanian, Farsi and Vietnamese letters are remapped,
// and Hiragana, Katakana, Bopomofo and Hangul each collapse to one
// representative. has_code is 0 on end-only and error results, and then
// code_point is 0. After an invalid lead byte, drop all bytes up to the
// end-of-text byte, which gives a closing error result.
// Depends on udsn_pkg, udsn_if, udsn_decode and udsn_fold.
module utf8_decode_script_normalize (
    input  logic         i_clk,
    input  logic         i_rst_n,
    udsn_byte_if.sink    i_byte,
    udsn_code_if.source  o_code
);

    // decoded, not yet folded, results between the two stages
    udsn_code_if u_raw ();

    // assemble sequences and track the abort state
    udsn_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .o_raw   (u_raw.source)
    );

    // fold by script and hold the result for the sink
    udsn_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raw   (u_raw.sink),
        .o_code  (o_code)
    );

endmodule

// ===== src/udsn_checker.sv =====
// udsn_checker: port-level assertions for utf8_decode_script_normalize and
// the bind that attaches them. Depends on udsn_pkg.
module udsn_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [udsn_pkg::CODE_W-1:0] i_code_point,
    input logic                        i_has_code,
    input logic                        i_bad_lead,
    input logic                        i_text_done
);

    // nothing left over from before reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_point)
            && $stable(i_has_code) && $stable(i_bad_lead) && $stable(i_text_done))
        else $error("stalled result changed");

    // a character and an error never share one result
    a_code_or_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_has_code && i_bad_lead))
        else $error("character flagged as error");

    // results without a character carry a zero code point
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_code |-> i_code_point == '0)
        else $error("code point on empty result");

    // a result without a character is an error or closes the text
    a_empty_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_code |-> i_bad_lead || i_text_done)
        else $error("empty result without a cause");

endmodule

bind utf8_decode_script_normalize udsn_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_code.valid),
    .i_out_ready  (o_code.ready),
    .i_code_point (o_code.code_point),
    .i_has_code   (o_code.has_code),
    .i_bad_lead   (o_code.bad_lead),
    .i_text_done  (o_code.text_done)
);
